// ===== hw/rtl/bdst_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the boost duty step tuner.
// No dependencies; imported by every module of the block.
package bdst_pkg;

  localparam int DUTY_TOP_DEF = 47;
  localparam int CFG_AW       = 3;
  localparam int CFG_DW       = 16;

  // input operation codes (travel on s_tuser)
  typedef enum logic [1:0] {
    OP_DISABLE = 2'd0,
    OP_START   = 2'd1,
    OP_SAMPLE  = 2'd2,
    OP_UNUSED  = 2'd3
  } op_t;

  // configuration register indexes
  typedef enum logic [CFG_AW-1:0] {
    CFG_TARGET  = 3'd0,
    CFG_MIN     = 3'd1,
    CFG_MAX     = 3'd2,
    CFG_VREF    = 3'd3,
    CFG_DIVIDER = 3'd4
  } cfg_idx_t;

  // tuning phases
  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_RAMP_UP   = 3'd1,
    PH_RAMP_DOWN = 3'd2,
    PH_STEP_DOWN = 3'd3,
    PH_STEP_UP   = 3'd4
  } phase_t;

  typedef struct packed {
    logic [15:0] goal_mv;
    logic [5:0]  duty_floor;
    logic [5:0]  duty_ceil;
    logic [12:0] supply_ref_mv;
    logic [13:0] divider_ratio;
  } cfg_t;

  // controller -> datapath commands
  typedef struct packed {
    logic load;  // capture item, apply disable/start
    logic mul1;  // adc * vref
    logic div1;  // reciprocal estimate of /1023
    logic fix1;  // remainder correction
    logic mul2;  // sensed * divider
    logic div2;  // reciprocal estimate of /1000
    logic fix2;  // remainder correction
    logic tune;  // one phase evaluation
    logic emit;  // load output register
  } cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic tune_done;
  } stat_t;

  // scaling constants: q ~= (x * RECIP) >> SHIFT, then one correction
  localparam int DIV1       = 1023;
  localparam int SHIFT1     = 23;
  localparam int RECIP1     = (1 << SHIFT1) / DIV1;
  localparam int DIV2       = 1000;
  localparam int SHIFT2     = 27;
  localparam int RECIP2     = (1 << SHIFT2) / DIV2;

endpackage

// ===== hw/rtl/bdst_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for the boost duty step tuner: input/output handshakes and
// datapath command issue. Depends on bdst_pkg.
module bdst_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  bdst_pkg::op_t     op,
  output logic              m_tvalid,
  input  logic              m_tready,
  output bdst_pkg::cmd_t    cmd,
  input  bdst_pkg::stat_t   stat
);
  import bdst_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_MUL1 = 9'b000000010,
    ST_DIV1 = 9'b000000100,
    ST_FIX1 = 9'b000001000,
    ST_MUL2 = 9'b000010000,
    ST_DIV2 = 9'b000100000,
    ST_FIX2 = 9'b001000000,
    ST_TUNE = 9'b010000000,
    ST_OUT  = 9'b100000000
  } state_t;

  state_t state, state_next;
  logic   out_valid, out_valid_next;

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = (op == OP_SAMPLE) ? ST_MUL1 : ST_OUT;
        end
      end
      ST_MUL1: begin cmd.mul1 = 1'b1; state_next = ST_DIV1; end
      ST_DIV1: begin cmd.div1 = 1'b1; state_next = ST_FIX1; end
      ST_FIX1: begin cmd.fix1 = 1'b1; state_next = ST_MUL2; end
      ST_MUL2: begin cmd.mul2 = 1'b1; state_next = ST_DIV2; end
      ST_DIV2: begin cmd.div2 = 1'b1; state_next = ST_FIX2; end
      ST_FIX2: begin cmd.fix2 = 1'b1; state_next = ST_TUNE; end
      ST_TUNE: begin
        cmd.tune = 1'b1;
        if (stat.tune_done) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid || m_tready) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.emit) out_valid_next = 1'b1;
    else if (m_tready) out_valid_next = 1'b0;
    else out_valid_next = out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== hw/rtl/bdst_dpath.sv =====
`timescale 1ns / 1ps
// Datapath for the boost duty step tuner: millivolt scaling, duty/phase
// state and output register. Depends on bdst_pkg.
module bdst_dpath #(
  parameter int DUTY_TOP = bdst_pkg::DUTY_TOP_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  bdst_pkg::cmd_t    cmd,
  output bdst_pkg::stat_t   stat,
  input  bdst_pkg::cfg_t    cfg,
  input  bdst_pkg::op_t     op,
  input  logic [9:0]        adc_sample,
  output logic [5:0]        duty_out,
  output logic              done_out,
  output logic [15:0]       mv_out
);
  import bdst_pkg::*;

  localparam int DutyLim = (DUTY_TOP > 63) ? 63 : DUTY_TOP;

  logic [9:0]  adc;
  logic [26:0] prod;
  logic [17:0] est;
  logic [17:0] mv;
  logic [5:0]  duty, duty_next;
  phase_t      phase, phase_next;
  logic        step_done;

  logic [36:0] t1;
  logic [44:0] t2;
  logic [22:0] r1;
  logic [26:0] r2;
  logic [5:0]  lo, hi;
  logic        at_target;

  assign t1 = 37'(prod[22:0]) * 37'(RECIP1);
  assign t2 = 45'(prod) * 45'(RECIP2);
  assign r1 = prod[22:0] - 23'(est[12:0]) * 23'(DIV1);
  assign r2 = prod - 27'(est) * 27'(DIV2);

  assign lo = (cfg.duty_floor > 6'(DutyLim)) ? 6'(DutyLim) : cfg.duty_floor;
  assign hi = (cfg.duty_ceil > 6'(DutyLim)) ? 6'(DutyLim) : cfg.duty_ceil;
  assign at_target = (mv >= 18'(cfg.goal_mv));

  // one phase evaluation; step_done low means the phase fell through
  always_comb begin
    duty_next  = duty;
    phase_next = phase;
    step_done  = 1'b1;
    case (phase)
      PH_RAMP_UP: begin
        if (duty < lo) duty_next = duty + 6'd1;
        else begin
          phase_next = PH_RAMP_DOWN;
          step_done  = 1'b0;
        end
      end
      PH_RAMP_DOWN: begin
        if (duty > hi) duty_next = duty - 6'd1;
        else begin
          phase_next = PH_STEP_DOWN;
          step_done  = 1'b0;
        end
      end
      PH_STEP_DOWN: begin
        if (duty > lo) begin
          if (!at_target) phase_next = PH_STEP_UP;
          else duty_next = duty - 6'd1;
        end else begin
          phase_next = PH_STEP_UP;
          step_done  = 1'b0;
        end
      end
      PH_STEP_UP: begin
        if (duty < hi) begin
          if (at_target) begin
            if (duty > lo) duty_next = duty - 6'd1;
            phase_next = PH_IDLE;
          end else duty_next = duty + 6'd1;
        end else phase_next = PH_IDLE;
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  assign stat.tune_done = step_done;

  // architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      duty  <= '0;
      phase <= PH_IDLE;
    end else if (cmd.load) begin
      if (op == OP_DISABLE) begin
        duty  <= '0;
        phase <= PH_IDLE;
      end else if (op == OP_START) phase <= PH_RAMP_UP;
    end else if (cmd.tune) begin
      duty  <= duty_next;
      phase <= phase_next;
    end
  end

  // scaling pipeline registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      adc <= adc_sample;
      mv  <= '0;
    end
    if (cmd.mul1) prod <= 27'(23'(adc) * 23'(cfg.supply_ref_mv));
    if (cmd.div1) est  <= 18'(t1[36:SHIFT1]);
    if (cmd.fix1) mv   <= (r1 >= 23'(DIV1)) ? est + 18'd1 : est;
    if (cmd.mul2) prod <= 27'(mv[12:0]) * 27'(cfg.divider_ratio);
    if (cmd.div2) est  <= t2[44:SHIFT2];
    if (cmd.fix2) mv   <= (r2 >= 27'(DIV2)) ? est + 18'd1 : est;
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      duty_out <= duty;
      done_out <= (phase == PH_IDLE);
      mv_out   <= (mv[17:16] != 2'b00) ? 16'hFFFF : mv[15:0];
    end
  end

endmodule

// ===== hw/rtl/boost_duty_step_tuner_top.sv =====
`timescale 1ns / 1ps
// Top level of the boost duty step tuner: configuration registers and the
// controller/datapath pair. Depends on bdst_pkg, bdst_ctrl, bdst_dpath.

// Each input transfer carries an operation on s_tuser (disable, start or
// sample) and, for a sample, a 10-bit ADC reading on s_tdata; every transfer
// yields exactly one result transfer with the duty after the step, a done
// flag (high when idle) and the sample's voltage in mV, saturated to 16 bits
// (0 for non-sample operations). Disable and start go from accept straight
// to the output state. A sample first passes through scaling (two multiply,
// reciprocal-estimate and correction rounds for /1023 and /1000) and then
// through tuning phase evaluations in order, going on to the next phase
// whenever one is skipped. s_tready is high whenever the sequencer is idle,
// so the next item is taken while a result still waits in the output register.
// Configuration writes are taken at any cycle but belong in idle periods.
module boost_duty_step_tuner_top #(
  parameter int DUTY_TOP = bdst_pkg::DUTY_TOP_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [15:0]                s_tdata,   // [9:0] adc_sample
  input  logic [1:0]                 s_tuser,   // [1:0] operation
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [23:0]                m_tdata,   // [5:0] duty, [6] done_res,
                                                // [22:7] measured_mv
  input  logic                       cfg_we,
  input  logic [bdst_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [bdst_pkg::CFG_DW-1:0] cfg_wdata
);
  import bdst_pkg::*;

  localparam int DutyLim = (DUTY_TOP > 63) ? 63 : DUTY_TOP;

  cfg_t        cfg;
  cmd_t        cmd;
  stat_t       stat;
  op_t         op;
  logic [5:0]  duty_out;
  logic        done_out;
  logic [15:0] mv_out;

  assign op = op_t'(s_tuser);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.goal_mv       <= 16'd18000;
      cfg.duty_floor    <= 6'd0;
      cfg.duty_ceil     <= 6'd47;
      cfg.supply_ref_mv <= 13'd5000;
      cfg.divider_ratio <= 14'd6100;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_TARGET:  cfg.goal_mv       <= cfg_wdata;
        CFG_MIN:     cfg.duty_floor    <= cfg_wdata[5:0];
        CFG_MAX:     cfg.duty_ceil     <= cfg_wdata[5:0];
        CFG_VREF:    cfg.supply_ref_mv <= cfg_wdata[12:0];
        CFG_DIVIDER: cfg.divider_ratio <= cfg_wdata[13:0];
        default: ;
      endcase
    end
  end

  bdst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .op       (op),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  bdst_dpath #(
    .DUTY_TOP (DUTY_TOP)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg        (cfg),
    .op         (op),
    .adc_sample (s_tdata[9:0]),
    .duty_out   (duty_out),
    .done_out   (done_out),
    .mv_out     (mv_out)
  );

  assign m_tdata = {1'b0, mv_out, done_out, duty_out};

`ifndef SYNTHESIS
  // duty never leaves the clamped range
  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[5:0] <= 6'(DutyLim)))
    else $error("duty above limit");

  // one item at a time: the sequencer is busy right after a transfer in
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while busy");

  // disable/start/unused pass through the output state to the output when it is free
  a_short_latency: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tuser != OP_SAMPLE) && !m_tvalid) |-> ##2 m_tvalid)
    else $error("control result late");
`endif

endmodule
